// ===== rtl/core/cpio_pkg.sv =====
// Package for the cpio newc stream deframer: beat types, parser state,
// phase and kind codes, and the character tables.
// No dependencies; used by cpio_step and cpio_newc_stream_deframer_core.
package cpio_pkg;

    localparam int MAX_FILES  = 1024;
    localparam int FILE_CNT_W = $clog2(MAX_FILES + 1);
    localparam int INDEX_W    = 10;

    localparam logic [6:0]  HEADER_LAST       = 7'd109;
    localparam logic [6:0]  MAGIC_LEN         = 7'd6;
    localparam logic [6:0]  FILESIZE_AT       = 7'd54;
    localparam logic [6:0]  FILESIZE_END      = 7'd62;
    localparam logic [6:0]  NAMESIZE_AT       = 7'd94;
    localparam logic [6:0]  NAMESIZE_END      = 7'd102;
    localparam logic [31:0] TRAILER_NAME_SIZE = 32'd11;
    localparam logic [3:0]  TRAILER_LEN       = 4'd10;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME,
        KIND_DATA,
        KIND_END,
        KIND_BAD_MAGIC,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       restart;
    } in_beat_t;

    typedef struct packed {
        kind_t              kind;
        logic [INDEX_W-1:0] file_index;
        logic [7:0]         value;
        logic               last_of_run;
    } out_beat_t;

    typedef struct packed {
        phase_t                phase;
        logic [6:0]            header_offset;
        logic [31:0]           name_length;
        logic [31:0]           data_length;
        logic [31:0]           byte_count;
        logic [FILE_CNT_W-1:0] file_count;
        logic                  trailer_match;
        logic [1:0]            stream_position_low;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:               PH_HEADER,
        header_offset:       7'd0,
        name_length:         32'd0,
        data_length:         32'd0,
        byte_count:          32'd0,
        file_count:          '0,
        trailer_match:       1'b1,
        stream_position_low: 2'd0
    };

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h30;
            3'd1:    c = 8'h37;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h37;
            3'd4:    c = 8'h30;
            3'd5:    c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h54;
            4'd1:    c = 8'h52;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

// ===== rtl/core/cpio_step.sv =====
// Per-byte parser step: next state and optional result beat for one byte.
// Depends on cpio_pkg.
module cpio_step (
    input  cpio_pkg::state_t   cur,
    input  cpio_pkg::in_beat_t beat,
    output cpio_pkg::state_t   nxt,
    output logic               emit,
    output cpio_pkg::out_beat_t res
);

    function automatic cpio_pkg::state_t start_header(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        r.phase = cpio_pkg::PH_HEADER;
        r.header_offset = 7'd0;
        return r;
    endfunction

    function automatic cpio_pkg::state_t start_data(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        r.byte_count = 32'd0;
        if (s.data_length == 32'd0)
        begin
            r.file_count = s.file_count + cpio_pkg::FILE_CNT_W'(1);
            r = start_header(r);
        end
        else
        begin
            r.phase = cpio_pkg::PH_DATA;
        end
        return r;
    endfunction

    function automatic cpio_pkg::state_t finish_name(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        if (s.stream_position_low == 2'd0)
        begin
            r = start_data(s);
        end
        else
        begin
            r.phase = cpio_pkg::PH_NAME_PAD;
        end
        return r;
    endfunction

    cpio_pkg::state_t s;
    logic [7:0]  b;
    logic        full;
    logic [6:0]  off;
    logic [31:0] pos;
    logic [31:0] pos1;
    logic        last;
    logic [cpio_pkg::FILE_CNT_W+cpio_pkg::INDEX_W-1:0] idx_ext;

    assign b = beat.archive_byte;
    assign s = beat.restart ? cpio_pkg::STATE_RESET : cur;
    assign full = s.file_count >= cpio_pkg::FILE_CNT_W'(cpio_pkg::MAX_FILES);
    assign off = s.header_offset;
    assign pos = s.byte_count;
    assign pos1 = pos + 32'd1;
    assign idx_ext = {{cpio_pkg::INDEX_W{1'b0}}, s.file_count};

    always_comb
    begin
        nxt = s;
        emit = 1'b0;
        res.kind = cpio_pkg::KIND_NAME;
        res.file_index = idx_ext[cpio_pkg::INDEX_W-1:0];
        res.value = 8'd0;
        res.last_of_run = 1'b0;
        last = 1'b0;
        if (s.phase != cpio_pkg::PH_DONE)
        begin
            nxt.stream_position_low = s.stream_position_low + 2'd1;
            case (s.phase)
                cpio_pkg::PH_HEADER:
                begin
                    if (off < cpio_pkg::MAGIC_LEN && b != cpio_pkg::magic_char(off[2:0]))
                    begin
                        nxt.phase = cpio_pkg::PH_DONE;
                        emit = 1'b1;
                        res.kind = cpio_pkg::KIND_BAD_MAGIC;
                    end
                    else
                    begin
                        if (off >= cpio_pkg::FILESIZE_AT && off < cpio_pkg::FILESIZE_END)
                        begin
                            nxt.data_length = {s.data_length[27:0], cpio_pkg::hex_value(b)};
                        end
                        else if (off >= cpio_pkg::NAMESIZE_AT && off < cpio_pkg::NAMESIZE_END)
                        begin
                            nxt.name_length = {s.name_length[27:0], cpio_pkg::hex_value(b)};
                        end
                        if (off != cpio_pkg::HEADER_LAST)
                        begin
                            nxt.header_offset = off + 7'd1;
                        end
                        else
                        begin
                            nxt.header_offset = 7'd0;
                            nxt.byte_count = 32'd0;
                            nxt.trailer_match = 1'b1;
                            if (nxt.name_length == 32'd0)
                            begin
                                if (full)
                                begin
                                    nxt.phase = cpio_pkg::PH_DONE;
                                    emit = 1'b1;
                                    res.kind = cpio_pkg::KIND_FULL;
                                end
                                else
                                begin
                                    nxt = finish_name(nxt);
                                end
                            end
                            else
                            begin
                                nxt.phase = cpio_pkg::PH_NAME;
                            end
                        end
                    end
                end
                cpio_pkg::PH_NAME:
                begin
                    last = pos1 == s.name_length;
                    if (pos[31:4] == 28'd0 && pos[3:0] < cpio_pkg::TRAILER_LEN)
                    begin
                        if (b != cpio_pkg::trailer_char(pos[3:0]))
                        begin
                            nxt.trailer_match = 1'b0;
                        end
                    end
                    else if (pos[31:4] == 28'd0 && pos[3:0] == cpio_pkg::TRAILER_LEN)
                    begin
                        if (b != 8'd0)
                        begin
                            nxt.trailer_match = 1'b0;
                        end
                    end
                    else
                    begin
                        nxt.trailer_match = 1'b0;
                    end
                    nxt.byte_count = pos1;
                    if (!last)
                    begin
                        emit = !full;
                        res.value = b;
                    end
                    else if (nxt.trailer_match
                             && s.name_length == cpio_pkg::TRAILER_NAME_SIZE)
                    begin
                        nxt.phase = cpio_pkg::PH_DONE;
                        emit = 1'b1;
                        res.kind = cpio_pkg::KIND_END;
                    end
                    else if (full)
                    begin
                        nxt.phase = cpio_pkg::PH_DONE;
                        emit = 1'b1;
                        res.kind = cpio_pkg::KIND_FULL;
                    end
                    else
                    begin
                        emit = 1'b1;
                        res.value = b;
                        res.last_of_run = 1'b1;
                        nxt = finish_name(nxt);
                    end
                end
                cpio_pkg::PH_NAME_PAD:
                begin
                    if (nxt.stream_position_low == 2'd0)
                    begin
                        nxt = start_data(nxt);
                    end
                end
                cpio_pkg::PH_DATA:
                begin
                    last = pos1 == s.data_length;
                    emit = 1'b1;
                    res.kind = cpio_pkg::KIND_DATA;
                    res.value = b;
                    res.last_of_run = last;
                    nxt.byte_count = pos1;
                    if (last)
                    begin
                        nxt.file_count = s.file_count + cpio_pkg::FILE_CNT_W'(1);
                        if (nxt.stream_position_low == 2'd0)
                        begin
                            nxt = start_header(nxt);
                        end
                        else
                        begin
                            nxt.phase = cpio_pkg::PH_DATA_PAD;
                        end
                    end
                end
                cpio_pkg::PH_DATA_PAD:
                begin
                    if (nxt.stream_position_low == 2'd0)
                    begin
                        nxt = start_header(nxt);
                    end
                end
                default:
                begin
                    nxt.phase = cpio_pkg::PH_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/cpio_newc_stream_deframer_core.sv =====
// cpio newc stream deframer top level: input register, parser state, result register.
// Depends on cpio_pkg and cpio_step.
// Path: an accepted byte waits in the input register, passes the parser step and is
// registered in the result register, which drives res_valid and res_beat.
// Throughput: one archive byte per cycle while no result beat waits on res_stall;
// the input register absorbs one byte while a result beat waits on res_stall.
// Reset: rst_n clears the parser to the header phase and empties both registers.
module cpio_newc_stream_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                arc_valid,
    output logic                arc_stall,
    input  cpio_pkg::in_beat_t  arc_beat,
    output logic                res_valid,
    input  logic                res_stall,
    output cpio_pkg::out_beat_t res_beat
);

    cpio_pkg::state_t    state_reg;
    cpio_pkg::state_t    state_next;
    cpio_pkg::in_beat_t  in_beat_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    cpio_pkg::out_beat_t res_beat_reg;
    cpio_pkg::out_beat_t step_res;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                step_emit;
    logic                proc;
    logic                take;

    cpio_step u_step (
        .cur  (state_reg),
        .beat (in_beat_reg),
        .nxt  (state_next),
        .emit (step_emit),
        .res  (step_res)
    );

    assign proc = in_valid_reg && (!res_valid_reg || !res_stall);
    assign arc_stall = in_valid_reg && !proc;
    assign take = arc_valid && !arc_stall;
    assign in_valid_next = take || (in_valid_reg && !proc);
    assign res_valid_next = proc ? step_emit : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpio_pkg::STATE_RESET;
            in_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (proc)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_beat_reg <= arc_beat;
        end
        if (proc && step_emit)
        begin
            res_beat_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat = res_beat_reg;

`ifndef SYNTHESIS
    a_stall_needs_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
        arc_stall |-> in_valid_reg && res_valid_reg)
        else $error("input stalled without a held beat and a waiting result");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_beat.kind == cpio_pkg::KIND_END
                      || res_beat.kind == cpio_pkg::KIND_BAD_MAGIC
                      || res_beat.kind == cpio_pkg::KIND_FULL)
        |-> res_beat.value == 8'd0 && !res_beat.last_of_run)
        else $error("status beat carries data");

    a_status_stops: assert property (@(posedge clk) disable iff (!rst_n)
        proc && step_emit && (step_res.kind == cpio_pkg::KIND_END
                              || step_res.kind == cpio_pkg::KIND_BAD_MAGIC
                              || step_res.kind == cpio_pkg::KIND_FULL)
        |=> state_reg.phase == cpio_pkg::PH_DONE)
        else $error("parser did not stop after a status beat");

    a_file_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.file_count <= cpio_pkg::FILE_CNT_W'(cpio_pkg::MAX_FILES))
        else $error("file count beyond table size");
`endif

endmodule
